### rtl/bitmap_block_allocator_unit_assert.svh
// Assertion macros for the bitmap block allocator.
// Used by modules that declare clk and rst_n; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the interfaces and the top level.
package bba_pkg;

    // Default geometry
    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int MAP_BYTES_DEF  = 512;

    // Payload field widths
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    // Map byte constants: block b is bit (MSB_MASK >> b%8) of byte b/8
    localparam logic [BYTE_W-1:0] MSB_MASK  = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

### rtl/bba_if.sv
// Request and response channel interfaces for the bitmap block allocator.
// Depends on bba_pkg for field widths.
interface bba_req_if
    import bba_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [INDEX_W-1:0] block_num;

    modport source (output valid, output mode, output block_num, input ready);
    modport sink   (input valid, input mode, input block_num, output ready);
endinterface

interface bba_rsp_if
    import bba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_block;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  next_free;

    modport source (output valid, output status, output granted_block, output free_count,
                    output next_free, input ready);
    modport sink   (input valid, input status, input granted_block, input free_count,
                    input next_free, output ready);
endinterface

### rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/bitmap_block_allocator_unit.sv
// Bitmap block allocator top level: used-bit map in a byte-wide RAM, free count and hint.
// Depends on bba_pkg, bba_if.sv, bba_ram and bitmap_block_allocator_unit_assert.svh.
//
// Usage:
//   req channel (valid/ready): mode 0 allocates the lowest free block, mode 1 frees
//   block_num. rsp channel (valid/ready): one response per request with status,
//   granted_block, free_count and next_free (NUM_BLOCKS when no block is free).
//   One request is in flight at a time; req.ready is high only while idle.
//   A rejected request goes straight to the emit step; a free reads the target byte and
//   clears the bit if it was set; an allocate sets the bit at the hint and, when the
//   granted byte then holds no clear bit, reads the following map bytes in turn to find
//   the next clear bit (at most MAP_BYTES - 1 of them). A new request is taken in the
//   cycle after the response is loaded. The search reads one map byte per cycle from
//   the RAM read port. After reset the map RAM is cleared one byte per cycle with
//   req.ready low. The response sits in an output register; while the receiver
//   stalls it holds, and a finished request waits until the register is taken.
`include "bitmap_block_allocator_unit_assert.svh"

module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int MAP_BYTES  = MAP_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);

    localparam int ADDR_W   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int MAP_BITS = MAP_BYTES * 8;
    localparam int USABLE   = (NUM_BLOCKS < MAP_BITS) ? NUM_BLOCKS : MAP_BITS;
    localparam int BLK_W    = $clog2(NUM_BLOCKS + 1);
    localparam logic [BLK_W-1:0]  HINT_NONE = BLK_W'(NUM_BLOCKS);
    localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(MAP_BYTES - 1);

    // First clear bit of a map byte, counted from the MSB
    function automatic logic [2:0] first_clear(input logic [BYTE_W-1:0] v);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!v[7-i])
            begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    // Block number of a bit, or none when it lies beyond the usable limit
    function automatic logic [BLK_W-1:0] hint_of(input logic [ADDR_W-1:0] b,
                                                 input logic [2:0] k);
        logic [ADDR_W+2:0] blk;
        blk = {b, k};
        return (32'(blk) < 32'(USABLE)) ? BLK_W'(blk) : HINT_NONE;
    endfunction

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   byte_reg, byte_next;
    logic [2:0]          bit_reg, bit_next;
    logic                op_reg, op_next;
    status_t             res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_granted_reg, res_granted_next;
    logic [BLK_W-1:0]    count_reg, count_next;
    logic [BLK_W-1:0]    hint_reg, hint_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [INDEX_W-1:0]  out_granted_reg, out_granted_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [COUNT_W-1:0]  out_hint_reg, out_hint_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [BYTE_W-1:0]   rdata;
    logic [BYTE_W-1:0]   mask;
    logic [BYTE_W-1:0]   set_byte;
    logic [ADDR_W+2:0]   tgt_blk;
    logic                req_fire;

    bba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign mask     = MSB_MASK >> bit_reg;
    assign set_byte = rdata | mask;
    assign tgt_blk  = {byte_reg, bit_reg};

    // Hold state, control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            byte_reg      <= '0;
            count_reg     <= BLK_W'(USABLE);
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            count_reg     <= count_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bit_reg         <= bit_next;
        op_reg          <= op_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_count_reg   <= out_count_next;
        out_hint_reg    <= out_hint_next;
    end

    // Next state, RAM access and results
    always_comb
    begin
        state_next       = state_reg;
        byte_next        = byte_reg;
        bit_next         = bit_reg;
        op_next          = op_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        count_next       = count_reg;
        hint_next        = hint_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_count_next   = out_count_reg;
        out_hint_next    = out_hint_reg;
        we               = 1'b0;
        waddr            = byte_reg;
        wdata            = '0;
        raddr            = byte_reg;

        // Drop the response once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the map to zero after reset
                we = 1'b1;
                if (byte_reg == LAST_BYTE)
                begin
                    byte_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    byte_next = ADDR_W'(byte_reg + 1'b1);
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next          = req.mode;
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    if (req.mode == MODE_ALLOC)
                    begin
                        if (count_reg == '0 || 32'(hint_reg) >= 32'(USABLE))
                        begin
                            res_status_next = ST_NO_FREE;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            byte_next  = ADDR_W'(hint_reg >> 3);
                            bit_next   = hint_reg[2:0];
                            raddr      = ADDR_W'(hint_reg >> 3);
                            state_next = S_MODIFY;
                        end
                    end
                    else
                    begin
                        if (32'(req.block_num) >= 32'(USABLE))
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            byte_next  = ADDR_W'(req.block_num >> 3);
                            bit_next   = req.block_num[2:0];
                            raddr      = ADDR_W'(req.block_num >> 3);
                            state_next = S_MODIFY;
                        end
                    end
                end
            end

            S_MODIFY:
            begin
                // Read data for the target byte is valid; write it back when the bit changes
                if (op_reg == MODE_ALLOC)
                begin
                    we               = 1'b1;
                    wdata            = set_byte;
                    count_next       = BLK_W'(count_reg - 1'b1);
                    res_granted_next = INDEX_W'(hint_reg);
                    if (set_byte != BYTE_FULL)
                    begin
                        hint_next  = hint_of(byte_reg, first_clear(set_byte));
                        state_next = S_EMIT;
                    end
                    else if (byte_reg == LAST_BYTE)
                    begin
                        hint_next  = HINT_NONE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        byte_next  = ADDR_W'(byte_reg + 1'b1);
                        raddr      = ADDR_W'(byte_reg + 1'b1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if ((rdata & mask) != '0)
                    begin
                        we         = 1'b1;
                        wdata      = rdata & ~mask;
                        count_next = BLK_W'(count_reg + 1'b1);
                        if (32'(tgt_blk) < 32'(hint_reg))
                        begin
                            hint_next = BLK_W'(tgt_blk);
                        end
                    end
                    state_next = S_EMIT;
                end
            end

            S_SCAN:
            begin
                // Advance one map byte per cycle until a clear bit turns up or the last byte is reached
                if (rdata != BYTE_FULL)
                begin
                    hint_next  = hint_of(byte_reg, first_clear(rdata));
                    state_next = S_EMIT;
                end
                else if (byte_reg == LAST_BYTE)
                begin
                    hint_next  = HINT_NONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    byte_next = ADDR_W'(byte_reg + 1'b1);
                    raddr     = ADDR_W'(byte_reg + 1'b1);
                end
            end

            S_EMIT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    out_count_next   = COUNT_W'(count_reg);
                    out_hint_next    = COUNT_W'(hint_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_block = out_granted_reg;
    assign rsp.free_count    = out_count_reg;
    assign rsp.next_free     = out_hint_reg;

    // Checks
    `BBA_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_reg) <= 32'(USABLE),
        "free count exceeds the usable block count")
    `BBA_ASSERT_IMP(a_empty_hint, state_reg == S_IDLE && count_reg == '0,
        hint_reg == HINT_NONE, "no free block left but hint names one")
    `BBA_ASSERT_NXT(a_alloc_count, state_reg == S_MODIFY && op_reg == MODE_ALLOC,
        count_reg == BLK_W'($past(count_reg) - 1'b1), "allocate did not take one block")
    `BBA_ASSERT_IMP(a_grant_zero, out_valid_reg && out_status_reg != ST_OK,
        out_granted_reg == '0, "granted block non-zero on a failed request")
    `BBA_ASSERT_IMP(a_emit_src, $rose(out_valid_reg), $past(state_reg == S_EMIT),
        "response raised outside the emit step")

endmodule
